// ===== rtl/keypad_matrix_scanner_macros.svh =====
// Assertion macros for the keypad matrix scanner
`ifndef KEYPAD_MATRIX_SCANNER_MACROS_SVH
`define KEYPAD_MATRIX_SCANNER_MACROS_SVH
`ifndef ASSERT_OFF
`define KMS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define KMS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define KMS_ASSERT(lbl, prop, msg)
`define KMS_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/kms_pkg.sv =====
// Shared types, constants and key table for the keypad matrix scanner
`timescale 1ns / 1ps

package kms_pkg;

    localparam int COLUMNS      = 3;
    localparam int ROWS         = 5;
    localparam int INPUT_ROWS   = 5;
    localparam int DRIVE_W      = 3;
    localparam int CODE_W       = 8;
    localparam int COUNT_W      = 8;
    localparam int COL_W        = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int TABLE_ROWS   = 5;
    localparam int TABLE_COLS   = 3;
    localparam logic [COUNT_W-1:0] HOLD_LIMIT      = COUNT_W'(250);
    localparam logic [COUNT_W-1:0] LONG_TICKS_INIT = COUNT_W'(10);

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_PRESS = 2'd1,
        EV_LONG  = 2'd2
    } t_key_event;

    typedef struct packed {
        logic [DRIVE_W-1:0] column_drive;
        t_key_event         key_event;
        logic [CODE_W-1:0]  key_code;
    } t_result;

    typedef logic [CODE_W-1:0] t_code_row [TABLE_COLS];

    localparam t_code_row KEY_TABLE [TABLE_ROWS] = '{
        '{8'h43, 8'h4D, 8'h52},   // C M R
        '{8'h31, 8'h32, 8'h33},   // 1 2 3
        '{8'h34, 8'h35, 8'h36},   // 4 5 6
        '{8'h37, 8'h38, 8'h39},   // 7 8 9
        '{8'h2A, 8'h30, 8'h23}    // * 0 #
    };

    // Positions outside the printed table read as no key
    function automatic logic [CODE_W-1:0] key_lookup(input int row,
                                                      input logic [COL_W-1:0] col);
        logic [CODE_W-1:0] code;
        code = '0;
        if (row < TABLE_ROWS && int'(col) < TABLE_COLS) begin
            code = KEY_TABLE[row][int'(col)];
        end
        return code;
    endfunction

endpackage

// ===== rtl/kms_core.sv =====
// Scan state, sweep latch, hold tracking and per-item result
`timescale 1ns / 1ps

module kms_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [kms_pkg::COUNT_W-1:0]   i_cfg_wr_data,
    input  logic                          i_accept,
    input  logic [kms_pkg::INPUT_ROWS-1:0] i_row_levels,
    output kms_pkg::t_result              o_result
);

    logic [kms_pkg::COUNT_W-1:0] r_long_ticks;
    logic [kms_pkg::COL_W-1:0]   r_scan_column, n_scan_column;
    logic [kms_pkg::CODE_W-1:0]  r_sweep_code,  n_sweep_code;
    logic [kms_pkg::CODE_W-1:0]  r_held_code,   n_held_code;
    logic [kms_pkg::COUNT_W-1:0] r_hold_count,  n_hold_count;

    logic [kms_pkg::COUNT_W-1:0] bumped_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_ticks  <= kms_pkg::LONG_TICKS_INIT;
            r_scan_column <= '0;
            r_sweep_code  <= '0;
            r_held_code   <= '0;
            r_hold_count  <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_long_ticks <= i_cfg_wr_data;
            end
            if (i_accept) begin
                r_scan_column <= n_scan_column;
                r_sweep_code  <= n_sweep_code;
                r_held_code   <= n_held_code;
                r_hold_count  <= n_hold_count;
            end
        end
    end

    always_comb begin
        // latch cleared at column 0; last active row wins
        n_sweep_code = (r_scan_column == '0) ? '0 : r_sweep_code;
        for (int r = 0; r < kms_pkg::ROWS && r < kms_pkg::INPUT_ROWS; r++) begin
            if (!i_row_levels[r]) begin
                n_sweep_code = kms_pkg::key_lookup(r, r_scan_column);
            end
        end

        if (int'(r_scan_column) >= kms_pkg::COLUMNS - 1) begin
            n_scan_column = '0;
        end else begin
            n_scan_column = r_scan_column + kms_pkg::COL_W'(1);
        end

        for (int b = 0; b < kms_pkg::DRIVE_W; b++) begin
            o_result.column_drive[b] = (int'(n_scan_column) != b);
        end

        bumped_count = (r_hold_count < kms_pkg::HOLD_LIMIT)
                     ? r_hold_count + kms_pkg::COUNT_W'(1) : r_hold_count;

        n_held_code        = r_held_code;
        n_hold_count       = r_hold_count;
        o_result.key_event = kms_pkg::EV_NONE;
        o_result.key_code  = '0;

        if (n_scan_column == '0) begin
            if (n_sweep_code == r_held_code) begin
                if (n_sweep_code != '0) begin
                    n_hold_count = bumped_count;
                    if (bumped_count == r_long_ticks) begin
                        o_result.key_event = kms_pkg::EV_LONG;
                        o_result.key_code  = n_sweep_code;
                    end
                end
            end else if (n_sweep_code == '0) begin
                n_held_code = '0;
            end else if (r_held_code == '0) begin
                n_held_code        = n_sweep_code;
                n_hold_count       = '0;
                o_result.key_event = kms_pkg::EV_PRESS;
                o_result.key_code  = n_sweep_code;
            end
            // a different key while one is held is ignored
        end
    end

endmodule

// ===== rtl/kms_out_buf.sv =====
// Two-entry output register with skid slot for the result channel
`timescale 1ns / 1ps

module kms_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  kms_pkg::t_result i_data,
    output logic             o_space,
    output logic             o_valid,
    input  logic             i_ready,
    output kms_pkg::t_result o_data
);

    logic             r_main_valid, n_main_valid;
    logic             r_skid_valid, n_skid_valid;
    kms_pkg::t_result r_main, n_main;
    kms_pkg::t_result r_skid, n_skid;
    logic             pop;

    assign o_space = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;
    assign pop     = r_main_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_main <= n_main;
        r_skid <= n_skid;
    end

    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (pop) begin
            if (r_skid_valid) begin
                n_main       = r_skid;
                n_skid_valid = 1'b0;
            end else if (i_push) begin
                n_main = i_data;
            end else begin
                n_main_valid = 1'b0;
            end
        end else if (i_push) begin
            if (!r_main_valid) begin
                n_main       = i_data;
                n_main_valid = 1'b1;
            end else begin
                n_skid       = i_data;
                n_skid_valid = 1'b1;
            end
        end
    end

endmodule

// ===== rtl/keypad_matrix_scanner.sv =====
// Keypad matrix scanner: 3 columns by 5 rows, press and long-press events
//
// Input channel (i_valid / o_ready, i_row_levels): one item per tick, the
// five active-low row levels sampled under the column currently driven.
// Output channel (o_valid / i_ready): one result per item, carrying the
// active-low column drive for the next sample, the event code and the key.
// Events appear only on the item that ends a sweep (drive back to column 0).
// Each result is registered in the output buffer when its item is accepted.
// Throughput: one item per cycle while o_ready is high; the whole update is
// a single pass of table lookup and compares between the scan state and the
// output register. A two-entry output buffer keeps o_ready high while one
// result waits; once both entries are full o_ready is low until one is taken.
// Configuration: i_cfg_wr_en / i_cfg_wr_data write the long-press threshold
// (completed held sweeps); write only while idle.
// Reset (i_rst_n low, synchronous): column 0, no key held, threshold 10,
// output buffer empty.
`timescale 1ns / 1ps
`include "keypad_matrix_scanner_macros.svh"

module keypad_matrix_scanner (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [kms_pkg::COUNT_W-1:0]    i_cfg_wr_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [kms_pkg::INPUT_ROWS-1:0] i_row_levels,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [kms_pkg::DRIVE_W-1:0]    o_column_drive,
    output logic [1:0]                     o_key_event,
    output logic [kms_pkg::CODE_W-1:0]     o_key_code
);

    logic             accept;
    kms_pkg::t_result core_result;
    kms_pkg::t_result out_result;

    assign accept = i_valid && o_ready;

    kms_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (accept),
        .i_row_levels  (i_row_levels),
        .o_result      (core_result)
    );

    kms_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (core_result),
        .o_space (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (out_result)
    );

    assign o_column_drive = out_result.column_drive;
    assign o_key_event    = out_result.key_event;
    assign o_key_code     = out_result.key_code;

    `KMS_ASSERT_IMP(a_one_column_low, o_valid, $countones(o_column_drive) == kms_pkg::DRIVE_W - 1, "column drive must have exactly one low bit")
    `KMS_ASSERT_IMP(a_event_has_code, o_valid && o_key_event != kms_pkg::EV_NONE, o_key_code != '0, "event reported without key code")
    `KMS_ASSERT_IMP(a_event_at_wrap, o_valid && o_key_event != kms_pkg::EV_NONE, o_column_drive == 3'b110, "event outside sweep end")
    `KMS_ASSERT_IMP(a_no_code_idle, o_valid && o_key_event == kms_pkg::EV_NONE, o_key_code == '0, "key code set without event")

endmodule
